// File: hw/rtl/ttuv_pkg.sv
// shared types and constants for the triangle tangent block
// no dependencies
package ttuv_pkg;

    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int DELTA_W = 33;    // difference of two 32-bit coordinates
    localparam int ACC_W   = 67;    // exact x*y - z*w of two deltas
    localparam int QUEUE_DEPTH = 2;

    // one triangle, reduced to its edges and uv deltas
    typedef struct packed {
        logic [DELTA_W-1:0]      du1;
        logic [DELTA_W-1:0]      dv1;
        logic [DELTA_W-1:0]      du2;
        logic [DELTA_W-1:0]      dv2;
        logic [2:0][DELTA_W-1:0] e1;
        logic [2:0][DELTA_W-1:0] e2;
    } job_t;

endpackage

// File: hw/rtl/triangle_tangent_from_uv_top.sv
// top level of the per-triangle tangent block
// depends on ttuv_pkg, ttuv_front, ttuv_queue, ttuv_back
//
// usage
// - s_ channel: one triangle corner per word (position and uv, signed q16.16);
//   every third accepted word closes a triangle
// - m_ channel: one word per triangle, the unit tangent in signed q1.14 and
//   a degenerate flag (zero uv determinant or zero tangent, tangent zero)
// - the first two corners of a triangle are taken one per cycle and give no word
// - from its third corner a triangle passes through the job queue, a load into the
//   back end, the products on the one shared 33x33 multiplier, a check,
//   normalizing shifts, the squares, the square root (32 steps) and three
//   divisions, one per tangent component; degenerate triangles go from the
//   check straight to the output word
// - throughput is set by that back end, one triangle at a time; the intake and
//   a two-entry job queue keep taking corners while the back end works
// - when the receiver stalls, the finished word holds on the m_ ports, the
//   back end waits, and the queue fills before s_ready drops on a third corner
// - reset (aresetn low, synchronous) empties the queue, idles the back end and
//   starts a new triangle; held corners are not cleared
module triangle_tangent_from_uv_top #(
    parameter int OUT_FRAC_BITS = ttuv_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [31:0] s_tex_u,
    input  logic signed [31:0] s_tex_v,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_tan_x,
    output logic signed [15:0] m_tan_y,
    output logic signed [15:0] m_tan_z,
    output logic               m_degenerate
);
    import ttuv_pkg::*;

    // front to queue
    logic push_valid;
    logic push_ready;
    job_t push_data;
    // queue to back end
    logic pop_valid;
    logic pop_ready;
    job_t pop_data;

    ttuv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pos_x    (s_pos_x),
        .s_pos_y    (s_pos_y),
        .s_pos_z    (s_pos_z),
        .s_tex_u    (s_tex_u),
        .s_tex_v    (s_tex_v),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ttuv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back end holds its result until taken
    ttuv_back #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (pop_valid),
        .job_ready    (pop_ready),
        .job          (pop_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_tan_x      (m_tan_x),
        .m_tan_y      (m_tan_y),
        .m_tan_z      (m_tan_z),
        .m_degenerate (m_degenerate)
    );

endmodule

// File: hw/rtl/ttuv_front.sv
// corner intake: holds the first two corners, forms edges and uv deltas on the third
// depends on ttuv_pkg
module ttuv_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_pos_x,
    input  logic signed [31:0]   s_pos_y,
    input  logic signed [31:0]   s_pos_z,
    input  logic signed [31:0]   s_tex_u,
    input  logic signed [31:0]   s_tex_v,
    output logic                 push_valid,
    input  logic                 push_ready,
    output ttuv_pkg::job_t       push_data
);
    import ttuv_pkg::*;

    logic [1:0]         count_reg;
    logic signed [31:0] pos0_reg [3];
    logic signed [31:0] pos1_reg [3];
    logic signed [31:0] uv0_reg  [2];
    logic signed [31:0] uv1_reg  [2];
    logic signed [31:0] pos_in   [3];
    logic               third;

    assign pos_in[0] = s_pos_x;
    assign pos_in[1] = s_pos_y;
    assign pos_in[2] = s_pos_z;

    // count value three behaves like two
    assign third      = count_reg[1];
    assign s_ready    = !third || push_ready;
    assign push_valid = s_valid && third;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            push_data.e1[i] = DELTA_W'(pos1_reg[i]) - DELTA_W'(pos0_reg[i]);
            push_data.e2[i] = DELTA_W'(pos_in[i]) - DELTA_W'(pos0_reg[i]);
        end
        push_data.du1 = DELTA_W'(uv1_reg[0]) - DELTA_W'(uv0_reg[0]);
        push_data.dv1 = DELTA_W'(uv1_reg[1]) - DELTA_W'(uv0_reg[1]);
        push_data.du2 = DELTA_W'(s_tex_u) - DELTA_W'(uv0_reg[0]);
        push_data.dv2 = DELTA_W'(s_tex_v) - DELTA_W'(uv0_reg[1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else if (s_valid && s_ready) begin
            if (third) begin
                count_reg <= 2'd0;
            end else begin
                count_reg <= count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && !third) begin
            if (count_reg[0]) begin
                for (int i = 0; i < 3; i++) pos1_reg[i] <= pos_in[i];
                uv1_reg[0] <= s_tex_u;
                uv1_reg[1] <= s_tex_v;
            end else begin
                for (int i = 0; i < 3; i++) pos0_reg[i] <= pos_in[i];
                uv0_reg[0] <= s_tex_u;
                uv0_reg[1] <= s_tex_v;
            end
        end
    end

endmodule

// File: hw/rtl/ttuv_queue.sv
// short job queue between intake and the arithmetic back end
// depends on ttuv_pkg
module ttuv_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  ttuv_pkg::job_t  push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output ttuv_pkg::job_t  pop_data
);
    import ttuv_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    job_t            mem [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     fill_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = fill_reg != (PW+1)'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= PW'(wr_ptr_reg + 1'b1);
            if (do_pop)  rd_ptr_reg <= PW'(rd_ptr_reg + 1'b1);
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push_data;
    end

endmodule

// File: hw/rtl/ttuv_back.sv
// arithmetic back end: products on one shared multiplier, normalize,
// integer square root and per-component division (skipped for degenerate jobs), then the result register
// depends on ttuv_pkg
module ttuv_back #(
    parameter int OUT_FRAC_BITS = ttuv_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               job_valid,
    output logic               job_ready,
    input  ttuv_pkg::job_t     job,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_tan_x,
    output logic signed [15:0] m_tan_y,
    output logic signed [15:0] m_tan_z,
    output logic               m_degenerate
);
    import ttuv_pkg::*;

    localparam int QW   = OUT_FRAC_BITS + 2;   // quotient bits, q <= 2^ofb + 1
    localparam int NUMW = OUT_FRAC_BITS + 31;  // dividend bits
    localparam int DCW  = $clog2(QW + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_CHECK = 8'b0000_0100,
        S_NORM  = 8'b0000_1000,
        S_SQ    = 8'b0001_0000,
        S_SQRT  = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t                    state_reg;
    job_t                      job_reg;
    logic [3:0]                step_reg;
    logic signed [65:0]        prod_reg;
    logic signed [ACC_W-1:0]   det_reg;
    logic signed [ACC_W-1:0]   t_reg    [3];
    logic [ACC_W-1:0]          mag_reg  [3];
    logic                      neg_reg  [3];
    logic [61:0]               s2_reg;
    logic [63:0]               v_reg;
    logic [63:0]               r_reg;
    logic [63:0]               bit_reg;
    logic [1:0]                comp_reg;
    logic [DCW-1:0]            dcnt_reg;
    logic [30:0]               rem_reg;
    logic [QW-1:0]             low_reg;
    logic [QW-1:0]             q_reg;
    logic signed [15:0]        tan_reg  [3];
    logic                      degen_reg;

    logic signed [DELTA_W-1:0] mul_a;
    logic signed [DELTA_W-1:0] mul_b;
    logic [2:0]                pidx;
    logic signed [ACC_W-1:0]   prod_ext;
    logic [ACC_W-1:0]          or_v;
    logic [61:0]               s2_sum;
    logic [63:0]               rb;
    logic [30:0]               len;
    logic [NUMW-1:0]           num;
    logic [31:0]               rem2;
    logic                      ge;
    logic [QW-1:0]             q_step;
    logic [31:0]               q32;
    logic [15:0]               qmag;
    logic signed [15:0]        tan_w;
    logic [ACC_W-1:0]          mag_sel;

    assign job_ready    = state_reg == S_IDLE;
    assign m_valid      = state_reg == S_OUT;
    assign m_tan_x      = tan_reg[0];
    assign m_tan_y      = tan_reg[1];
    assign m_tan_z      = tan_reg[2];
    assign m_degenerate = degen_reg;

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_MUL) begin
            unique case (step_reg[2:0])
                3'd0: begin mul_a = $signed(job_reg.du1); mul_b = $signed(job_reg.dv2); end
                3'd1: begin mul_a = $signed(job_reg.du2); mul_b = $signed(job_reg.dv1); end
                3'd2: begin mul_a = $signed(job_reg.dv2); mul_b = $signed(job_reg.e1[0]); end
                3'd3: begin mul_a = $signed(job_reg.dv1); mul_b = $signed(job_reg.e2[0]); end
                3'd4: begin mul_a = $signed(job_reg.dv2); mul_b = $signed(job_reg.e1[1]); end
                3'd5: begin mul_a = $signed(job_reg.dv1); mul_b = $signed(job_reg.e2[1]); end
                3'd6: begin mul_a = $signed(job_reg.dv2); mul_b = $signed(job_reg.e1[2]); end
                3'd7: begin mul_a = $signed(job_reg.dv1); mul_b = $signed(job_reg.e2[2]); end
                default: ;
            endcase
        end else if (state_reg == S_SQ) begin
            mul_a = $signed({3'b000, mag_reg[step_reg[1:0] == 2'd3 ? 2'd0 : step_reg[1:0]][29:0]});
            mul_b = mul_a;
        end
    end

    assign pidx     = 3'(step_reg - 4'd1);
    assign prod_ext = {prod_reg[65], prod_reg};
    assign or_v     = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign s2_sum   = s2_reg + prod_reg[61:0];
    assign rb       = r_reg + bit_reg;
    assign len      = r_reg[30:0];
    assign mag_sel  = mag_reg[comp_reg];
    assign num      = (NUMW'(mag_sel[29:0]) << OUT_FRAC_BITS) + NUMW'(len >> 1);
    assign rem2     = {rem_reg, low_reg[QW-1]};
    assign ge       = rem2 >= {1'b0, len};
    assign q_step   = {q_reg[QW-2:0], ge};
    assign q32      = 32'(q_step);
    assign qmag     = (q32 > 32'd32767) ? 16'd32767 : q32[15:0];
    assign tan_w    = neg_reg[comp_reg] ? $signed(16'(-qmag)) : $signed(qmag);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: if (job_valid) state_reg <= S_MUL;
                S_MUL: if (step_reg == 4'd8) state_reg <= S_CHECK;
                S_CHECK: begin
                    if (det_reg == '0 || (t_reg[0] == '0 && t_reg[1] == '0 && t_reg[2] == '0)) begin
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_NORM;
                    end
                end
                S_NORM: if (or_v[ACC_W-1:29] == '0 + 1'b1) state_reg <= S_SQ;
                S_SQ: if (step_reg == 4'd3) state_reg <= S_SQRT;
                S_SQRT: if (bit_reg == '0) state_reg <= S_DIV;
                S_DIV: if (dcnt_reg == DCW'(QW) && comp_reg == 2'd2) state_reg <= S_OUT;
                S_OUT: if (m_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                job_reg  <= job;
                step_reg <= '0;
                det_reg  <= '0;
                for (int i = 0; i < 3; i++) t_reg[i] <= '0;
            end
            S_MUL: begin
                prod_reg <= mul_a * mul_b;
                step_reg <= step_reg + 4'd1;
                if (step_reg != 4'd0) begin
                    if (pidx[2:1] == 2'd0) begin
                        det_reg <= pidx[0] ? det_reg - prod_ext : det_reg + prod_ext;
                    end else begin
                        t_reg[pidx[2:1] - 2'd1] <= pidx[0] ? t_reg[pidx[2:1] - 2'd1] - prod_ext
                                                           : t_reg[pidx[2:1] - 2'd1] + prod_ext;
                    end
                end
            end
            S_CHECK: begin
                degen_reg <= 1'b1;
                for (int i = 0; i < 3; i++) begin
                    tan_reg[i] <= '0;
                    mag_reg[i] <= t_reg[i][ACC_W-1] ? ACC_W'(-t_reg[i]) : t_reg[i];
                    neg_reg[i] <= t_reg[i][ACC_W-1] ^ det_reg[ACC_W-1];
                end
                step_reg <= '0;
                s2_reg   <= '0;
            end
            S_NORM: begin
                // largest magnitude is brought to exactly 30 bits
                degen_reg <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                    priority if (or_v[ACC_W-1:38] != '0) begin
                        mag_reg[i] <= mag_reg[i] >> 8;
                    end else if (or_v[37:30] != '0) begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end else if (or_v[29:21] == '0) begin
                        mag_reg[i] <= mag_reg[i] << 8;
                    end else if (!or_v[29]) begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            S_SQ: begin
                prod_reg <= mul_a * mul_b;
                step_reg <= step_reg + 4'd1;
                if (step_reg != 4'd0) s2_reg <= s2_sum;
                v_reg    <= 64'(s2_sum);
                r_reg    <= '0;
                bit_reg  <= 64'd1 << 62;
            end
            S_SQRT: begin
                if (bit_reg != '0) begin
                    if (v_reg >= rb) begin
                        v_reg <= v_reg - rb;
                        r_reg <= (r_reg >> 1) + bit_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
                comp_reg <= '0;
                dcnt_reg <= '0;
            end
            S_DIV: begin
                if (dcnt_reg == '0) begin
                    rem_reg  <= 31'(num[NUMW-1:QW]);
                    low_reg  <= num[QW-1:0];
                    q_reg    <= '0;
                    dcnt_reg <= DCW'(1);
                end else begin
                    rem_reg <= ge ? 31'(rem2 - {1'b0, len}) : rem2[30:0];
                    low_reg <= low_reg << 1;
                    q_reg   <= q_step;
                    if (dcnt_reg == DCW'(QW)) begin
                        tan_reg[comp_reg] <= tan_w;
                        comp_reg          <= comp_reg + 2'd1;
                        dcnt_reg          <= '0;
                    end else begin
                        dcnt_reg <= dcnt_reg + 1'b1;
                    end
                end
            end
            S_OUT: ;
            default: ;
        endcase
    end

endmodule
